// File: hdl/clsfe_pkg.sv
// Package for the serial character LCD frame engine.
// Holds operation codes, frame constants and register indexes; no dependencies.
package clsfe_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_CHAR = 2'd0,
        OP_SEND_LINE  = 2'd1,
        OP_RX_BYTE    = 2'd2,
        OP_POLL_END   = 2'd3
    } t_op;

    localparam logic KIND_TX_BYTE    = 1'b0;
    localparam logic KIND_POLL_STATUS = 1'b1;

    localparam logic [7:0] HDR_SYNC0    = 8'hAA;
    localparam logic [7:0] HDR_SYNC1    = 8'h55;
    localparam logic [7:0] HDR_TX_CMD   = 8'h1E;
    localparam logic [7:0] HDR_RX_CMD   = 8'h16;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] BACKLIGHT_ADD = 8'h02;

    // Reply bytes kept per display and the saturation point of the count.
    localparam int RX_KEEP = 6;
    localparam int RX_SAT  = 16;
    localparam int RX_CNT_W = 5;

    // Header bytes ahead of the characters: sync0, sync1, command, length, mode.
    localparam int FRAME_HDR = 5;

    localparam logic REG_DISPLAY_ENABLE = 1'b0;
    localparam logic REG_BACKLIGHT_ON   = 1'b1;

endpackage

// File: hdl/char_lcd_serial_frame_engine_unit.sv
// A character write or a received byte is taken in the idle state, which it does not leave.
// A send line puts out a frame of LINE_CHARS+6 beats, one frame beat per cycle while the
// output is not stalled, fed by the line RAM read port; a poll end walks the reply RAM.
// Reset (synchronous, active low) starts a clearing pass over the line RAM, writing
// spaces to all 2*LINE_CHARS entries per display; no input is taken then.
// Depends on clsfe_pkg and clsfe_ram.
module char_lcd_serial_frame_engine_unit
    import clsfe_pkg::*;
#(
    parameter int DISPLAYS   = 2,
    parameter int LINE_CHARS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic        i_display_index,
    input  logic        i_line_select,
    input  logic [3:0]  i_column,
    input  logic [7:0]  i_char_value,
    input  logic [7:0]  i_rx_byte,

    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic [7:0]  o_buttons,
    output logic        o_frame_accepted,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The display index field is one bit wide, so at most two displays are reachable.
    localparam int DUSED  = (DISPLAYS < 2) ? 1 : 2;
    localparam int LDEPTH = DUSED * 2 * LINE_CHARS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int RDEPTH = DUSED * RX_KEEP;
    localparam int RAW    = $clog2(RDEPTH);
    localparam int FLEN   = LINE_CHARS + FRAME_HDR + 1;
    localparam int IW     = $clog2(FLEN);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SEND,
        S_POLL
    } t_state;

    t_state              r_state;
    logic [LAW-1:0]      r_clr;
    logic [1:0]          r_de;
    logic [1:0]          r_bl;
    logic                r_disp;
    logic                r_line;
    logic                r_en;
    logic [IW-1:0]       r_idx;
    logic [7:0]          r_sum;
    logic [7:0]          r_mode;
    logic [2:0]          r_pk;
    logic                r_ok;
    logic [7:0]          r_b4;
    logic [RX_CNT_W-1:0] r_cnt [DUSED];
    logic [7:0]          r_btn [DUSED];

    logic                r_ov;
    logic                r_kind;
    logic [7:0]          r_byte;
    logic                r_last;
    logic [7:0]          r_obtn;
    logic                r_acc;

    logic                accept;
    logic                d_ok;
    logic                col_ok;
    t_op                 op;
    logic                o_load;
    logic [IW-1:0]       n_idx;
    logic [IW-1:0]       cidx;
    logic [7:0]          tx_byte;
    logic [7:0]          ch_shown;

    logic                lr_we;
    logic [LAW-1:0]      lr_waddr;
    logic [7:0]          lr_wdata;
    logic [LAW-1:0]      lr_raddr;
    logic [7:0]          lr_rdata;

    logic                rr_we;
    logic [RAW-1:0]      rr_waddr;
    logic [RAW-1:0]      rr_raddr;
    logic [7:0]          rr_rdata;
    logic [2:0]          pk_rd;
    logic                poll_acc;
    logic                cfg_we;

    assign op      = t_op'(i_op);
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign d_ok    = int'(i_display_index) < DISPLAYS;
    assign col_ok  = int'(i_column) < LINE_CHARS;
    assign o_load  = !r_ov || i_ready;

    // Line RAM: the clearing pass owns the write port until it finishes.
    assign lr_we    = (r_state == S_CLEAR) ||
                      (accept && op == OP_WRITE_CHAR && d_ok && col_ok);
    assign lr_waddr = (r_state == S_CLEAR) ? r_clr :
                      LAW'({i_display_index, i_line_select}) * LAW'(LINE_CHARS)
                      + LAW'(i_column);
    assign lr_wdata = (r_state == S_CLEAR) ? CHAR_SPACE : i_char_value;

    // The read address follows the beat that will be presented next, so the
    // registered read data lines up with r_idx and holds while the output stalls.
    always_comb begin
        n_idx = r_idx;
        if (r_state == S_SEND && o_load) begin
            n_idx = r_idx + IW'(1);
        end
        if (n_idx < IW'(FRAME_HDR)) begin
            cidx = '0;
        end else if (n_idx - IW'(FRAME_HDR) >= IW'(LINE_CHARS)) begin
            cidx = IW'(LINE_CHARS - 1);
        end else begin
            cidx = n_idx - IW'(FRAME_HDR);
        end
    end

    assign lr_raddr = LAW'({r_disp, r_line}) * LAW'(LINE_CHARS) + LAW'(cidx);
    assign ch_shown = (lr_rdata == 8'h00) ? CHAR_SPACE : lr_rdata;

    always_comb begin
        if (r_idx == IW'(0)) begin
            tx_byte = HDR_SYNC0;
        end else if (r_idx == IW'(1)) begin
            tx_byte = HDR_SYNC1;
        end else if (r_idx == IW'(2)) begin
            tx_byte = HDR_TX_CMD;
        end else if (r_idx == IW'(3)) begin
            tx_byte = 8'(LINE_CHARS + 2);
        end else if (r_idx == IW'(4)) begin
            tx_byte = r_mode;
        end else if (r_idx == IW'(FLEN - 1)) begin
            tx_byte = 8'h00 - r_sum;
        end else begin
            tx_byte = ch_shown;
        end
    end

    clsfe_ram #(
        .WIDTH (8),
        .DEPTH (LDEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (lr_we),
        .i_waddr (lr_waddr),
        .i_wdata (lr_wdata),
        .i_raddr (lr_raddr),
        .o_rdata (lr_rdata)
    );

    // Reply RAM: only the first bytes after a poll are kept.
    assign rr_we    = accept && op == OP_RX_BYTE && d_ok &&
                      r_cnt[i_display_index] < RX_CNT_W'(RX_KEEP);
    assign rr_waddr = RAW'(i_display_index) * RAW'(RX_KEEP)
                      + RAW'(r_cnt[i_display_index]);
    assign pk_rd    = (r_pk < 3'(RX_KEEP - 1)) ? r_pk : 3'(RX_KEEP - 1);
    assign rr_raddr = RAW'(r_disp) * RAW'(RX_KEEP) + RAW'(pk_rd);

    clsfe_ram #(
        .WIDTH (8),
        .DEPTH (RDEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rr_we),
        .i_waddr (rr_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (rr_raddr),
        .o_rdata (rr_rdata)
    );

    // The count check ensures that a reply never fully written cannot pass.
    assign poll_acc = r_en && r_cnt[r_disp] == RX_CNT_W'(RX_KEEP) && r_ok &&
                      8'(r_b4 + rr_rdata) == 8'h00;

    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_DISPLAY_ENABLE: prdata = {30'd0, r_de};
            REG_BACKLIGHT_ON:   prdata = {30'd0, r_bl};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_de    <= 2'b00;
            r_bl    <= 2'b11;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            r_pk    <= '0;
            for (int i = 0; i < DUSED; i++) begin
                r_cnt[i] <= '0;
                r_btn[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (paddr[2])
                    REG_DISPLAY_ENABLE: r_de <= pwdata[1:0];
                    REG_BACKLIGHT_ON:   r_bl <= pwdata[1:0];
                    default:            ;
                endcase
            end

            if (i_ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + LAW'(1);
                    if (r_clr == LAW'(LDEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_disp <= i_display_index;
                    r_line <= i_line_select;
                    r_en   <= r_de[i_display_index];
                    r_idx  <= '0;
                    r_pk   <= '0;
                    r_ok   <= 1'b1;
                    r_sum  <= 8'h00;
                    r_mode <= 8'(i_line_select) +
                              (r_bl[i_display_index] ? BACKLIGHT_ADD : 8'h00);
                    if (accept && d_ok) begin
                        case (op)
                            OP_SEND_LINE: begin
                                if (r_de[i_display_index]) begin
                                    r_state <= S_SEND;
                                end
                            end
                            OP_RX_BYTE: begin
                                if (r_cnt[i_display_index] < RX_CNT_W'(RX_SAT)) begin
                                    r_cnt[i_display_index] <=
                                        r_cnt[i_display_index] + RX_CNT_W'(1);
                                end
                            end
                            OP_POLL_END: r_state <= S_POLL;
                            default:     ;
                        endcase
                    end
                end
                S_SEND: begin
                    if (o_load) begin
                        r_ov   <= 1'b1;
                        r_kind <= KIND_TX_BYTE;
                        r_byte <= tx_byte;
                        r_last <= (r_idx == IW'(FLEN - 1));
                        r_obtn <= 8'h00;
                        r_acc  <= 1'b0;
                        r_idx  <= n_idx;
                        if (r_idx >= IW'(FRAME_HDR - 1) && r_idx < IW'(FLEN - 1)) begin
                            r_sum <= r_sum + tx_byte;
                        end
                        if (r_idx == IW'(FLEN - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_POLL: begin
                    // At step k the read data holds reply byte k-1.
                    if (r_pk < 3'(RX_KEEP)) begin
                        r_pk <= r_pk + 3'd1;
                        case (r_pk)
                            3'd1: r_ok <= r_ok && rr_rdata == HDR_SYNC0;
                            3'd2: r_ok <= r_ok && rr_rdata == HDR_SYNC1;
                            3'd3: r_ok <= r_ok && rr_rdata == HDR_RX_CMD;
                            3'd5: r_b4 <= rr_rdata;
                            default: ;
                        endcase
                    end else if (o_load) begin
                        r_ov   <= 1'b1;
                        r_kind <= KIND_POLL_STATUS;
                        r_byte <= 8'h00;
                        r_last <= 1'b0;
                        r_obtn <= poll_acc ? r_b4 : r_btn[r_disp];
                        r_acc  <= poll_acc;
                        if (poll_acc) begin
                            r_btn[r_disp] <= r_b4;
                        end
                        if (r_en) begin
                            r_cnt[r_disp] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_kind           = r_kind;
    assign o_out_byte       = r_byte;
    assign o_last_byte      = r_last;
    assign o_buttons        = r_obtn;
    assign o_frame_accepted = r_acc;

endmodule

// File: hdl/clsfe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module clsfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/char_lcd_serial_frame_engine_unit_tb.sv
// Self-checking testbench for the serial character LCD frame engine.
// Drives a directed table and then random phases, and checks every output beat
// against a cycle-free predictor of the engine. Depends on clsfe_pkg and char_lcd_serial_frame_engine_unit.
module char_lcd_serial_frame_engine_unit_tb
    import clsfe_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DISPLAYS     = 2;
    localparam int LINE_CHARS   = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 65;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       last_byte;
        logic [7:0] buttons;
        logic       frame_accepted;
    } t_beat;

    // One row of stimulus: either a register write or an input item.
    typedef struct {
        bit         is_reg;
        logic       reg_idx;
        logic [1:0] reg_val;
        t_op        op;
        logic       disp;
        logic       line;
        logic [3:0] col;
        logic [7:0] ch;
        logic [7:0] rxb;
        bit         typed;
        t_beat      typed_beat;
    } t_stim;

    typedef enum int {
        FAULT_NONE,
        FAULT_BIT_FLIP,
        FAULT_SHORT,
        FAULT_LONG
    } t_reply_fault;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic        i_display_index;
    logic        i_line_select;
    logic [3:0]  i_column;
    logic [7:0]  i_char_value;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic [7:0]  o_buttons;
    logic        o_frame_accepted;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    char_lcd_serial_frame_engine_unit #(
        .DISPLAYS   (DISPLAYS),
        .LINE_CHARS (LINE_CHARS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_display_index  (i_display_index),
        .i_line_select    (i_line_select),
        .i_column         (i_column),
        .i_char_value     (i_char_value),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_out_byte       (o_out_byte),
        .o_last_byte      (o_last_byte),
        .o_buttons        (o_buttons),
        .o_frame_accepted (o_frame_accepted),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Predictor state, indexed {display, line, column} for the text.
    logic [7:0]          char_mem [2*DISPLAYS*LINE_CHARS];
    logic [7:0]          reply_mem [DISPLAYS][RX_KEEP];
    logic [RX_CNT_W-1:0] reply_cnt [DISPLAYS];
    logic [7:0]          button_mem [DISPLAYS];
    logic [1:0]          enable_mask;
    logic [1:0]          backlight_mask;

    logic [7:0] reply_good [RX_KEEP] = '{8'hAA, 8'h55, 8'h16, 8'h00, 8'h5A, 8'hA6};
    logic [7:0] reply_bad  [RX_KEEP] = '{8'hAA, 8'h55, 8'h16, 8'h00, 8'h01, 8'h01};

    t_beat expected_beats[$];
    t_stim cmd_q[$];
    t_stim stim_rows[$];
    t_stim cur_item;

    int  items_total;
    int  items_done;
    int  err_count;
    int  tx_gap;
    int  rx_hold;
    int  hold_requests;
    int  holds_served;
    int  cycle_count;
    bit  tx_steady;
    bit  rx_steady;

    logic [1:0] phase_en [PHASES] = '{2'd3, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    logic [1:0] phase_bl [PHASES] = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd1};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_stim mk_item(input t_op op, input logic disp, input logic line,
                                      input logic [3:0] col, input logic [7:0] ch,
                                      input logic [7:0] rxb);
        t_stim s;
        s = '{op: OP_WRITE_CHAR, default: '0};
        s.op   = op;
        s.disp = disp;
        s.line = line;
        s.col  = col;
        s.ch   = ch;
        s.rxb  = rxb;
        return s;
    endfunction

    function automatic t_stim mk_poll_typed(input logic disp, input logic [7:0] btn,
                                            input logic acc);
        t_stim s;
        s = mk_item(OP_POLL_END, disp, 1'b0, 4'd0, 8'd0, 8'd0);
        s.typed      = 1'b1;
        s.typed_beat = '{kind: KIND_POLL_STATUS, out_byte: 8'd0, last_byte: 1'b0,
                         buttons: btn, frame_accepted: acc};
        return s;
    endfunction

    function automatic t_stim mk_reg(input logic idx, input logic [1:0] val);
        t_stim s;
        s = '{op: OP_WRITE_CHAR, default: '0};
        s.is_reg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic void push_frame_byte(input logic [7:0] b, input logic last);
        expected_beats.push_back('{kind: KIND_TX_BYTE, out_byte: b, last_byte: last,
                                   buttons: 8'd0, frame_accepted: 1'b0});
    endfunction

    function automatic void predict_lcd_beats(input t_stim s);
        logic [7:0] mode;
        logic [7:0] sum;
        logic [7:0] c;
        logic       acc;
        case (s.op)
            OP_WRITE_CHAR: begin
                char_mem[{s.disp, s.line, s.col}] = s.ch;
            end
            OP_SEND_LINE: begin
                if (enable_mask[s.disp]) begin
                    mode = {7'd0, s.line} + (backlight_mask[s.disp] ? BACKLIGHT_ADD : 8'd0);
                    push_frame_byte(HDR_SYNC0, 1'b0);
                    push_frame_byte(HDR_SYNC1, 1'b0);
                    push_frame_byte(HDR_TX_CMD, 1'b0);
                    push_frame_byte(8'(LINE_CHARS + 2), 1'b0);
                    push_frame_byte(mode, 1'b0);
                    sum = mode;
                    for (int i = 0; i < LINE_CHARS; i++) begin
                        c = char_mem[{s.disp, s.line, 4'(i)}];
                        if (c == 8'd0)
                            c = CHAR_SPACE;
                        sum += c;
                        push_frame_byte(c, 1'b0);
                    end
                    push_frame_byte(8'd0 - sum, 1'b1);
                end
            end
            OP_RX_BYTE: begin
                if (reply_cnt[s.disp] < RX_KEEP)
                    reply_mem[s.disp][reply_cnt[s.disp]] = s.rxb;
                if (reply_cnt[s.disp] < RX_SAT)
                    reply_cnt[s.disp]++;
            end
            default: begin
                acc = 1'b0;
                if (enable_mask[s.disp]) begin
                    if (reply_cnt[s.disp] == RX_KEEP
                            && reply_mem[s.disp][0] == HDR_SYNC0
                            && reply_mem[s.disp][1] == HDR_SYNC1
                            && reply_mem[s.disp][2] == HDR_RX_CMD
                            && 8'(reply_mem[s.disp][4] + reply_mem[s.disp][5]) == 8'd0) begin
                        button_mem[s.disp] = reply_mem[s.disp][4];
                        acc = 1'b1;
                    end
                    reply_cnt[s.disp] = '0;
                end
                expected_beats.push_back('{kind: KIND_POLL_STATUS, out_byte: 8'd0,
                                           last_byte: 1'b0, buttons: button_mem[s.disp],
                                           frame_accepted: acc});
            end
        endcase
    endfunction

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, got);
        end
    endfunction

    // Input side: one item in flight, with a random gap before each outside the steady phases.
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            predict_lcd_beats(cur_item);
            if (cur_item.typed) begin
                void'(expected_beats.pop_back());
                expected_beats.push_back(cur_item.typed_beat);
            end
            items_done++;
            tx_gap = tx_steady ? 0 : $urandom_range(0, 3);
        end
        if (!i_valid || o_ready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                cur_item = cmd_q.pop_front();
                i_valid         <= 1'b1;
                i_op            <= cur_item.op;
                i_display_index <= cur_item.disp;
                i_line_select   <= cur_item.line;
                i_column        <= cur_item.col;
                i_char_value    <= cur_item.ch;
                i_rx_byte       <= cur_item.rxb;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output side: checks each beat and stalls at random outside the steady phase, with a long hold on request.
    always @(posedge i_clk) begin
        t_beat want;
        if (o_valid && i_ready) begin
            if (expected_beats.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected beat, expected none actual kind %b byte %h",
                         $time, o_kind, o_out_byte);
            end else begin
                want = expected_beats.pop_front();
                compare_field("kind", 8'(want.kind), 8'(o_kind));
                compare_field("out_byte", want.out_byte, o_out_byte);
                compare_field("last_byte", 8'(want.last_byte), 8'(o_last_byte));
                compare_field("buttons", want.buttons, o_buttons);
                compare_field("frame_accepted", 8'(want.frame_accepted), 8'(o_frame_accepted));
            end
            rx_hold = rx_steady ? 0 : $urandom_range(0, 3);
        end
        if (holds_served < hold_requests) begin
            holds_served++;
            rx_hold = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (items_done != items_total || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {30'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DISPLAY_ENABLE)
            enable_mask = val;
        else
            backlight_mask = val;
    endtask

    task automatic queue_item(input t_stim s);
        cmd_q.push_back(s);
        items_total++;
    endtask

    // Mostly well-formed button replies followed by a poll, mixed with text
    // writes, line sends and stray bytes or polls.
    task automatic queue_random_phase(input int n);
        int           added;
        int           pick;
        int           idx;
        logic         d;
        logic [7:0]   btn;
        logic [7:0]   reply[$];
        t_reply_fault fault;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 9);
            d = 1'($urandom);
            if (pick <= 3) begin
                btn = 8'($urandom);
                reply = '{HDR_SYNC0, HDR_SYNC1, HDR_RX_CMD, 8'($urandom), btn, 8'd0 - btn};
                fault = ($urandom_range(0, 3) == 0) ? t_reply_fault'($urandom_range(1, 3))
                                                    : FAULT_NONE;
                idx = $urandom_range(0, RX_KEEP - 1);
                case (fault)
                    FAULT_BIT_FLIP: reply[idx][$urandom_range(0, 7)] ^= 1'b1;
                    FAULT_SHORT:    reply.delete(idx);
                    FAULT_LONG: begin
                        repeat ($urandom_range(1, 12)) reply.push_back(8'($urandom));
                    end
                    default: ;
                endcase
                foreach (reply[k]) begin
                    queue_item(mk_item(OP_RX_BYTE, d, 1'($urandom), 4'($urandom),
                                       8'($urandom), reply[k]));
                end
                queue_item(mk_item(OP_POLL_END, d, 1'($urandom), 4'($urandom),
                                   8'($urandom), 8'($urandom)));
                added += reply.size() + 1;
            end else if (pick <= 5) begin
                queue_item(mk_item(OP_WRITE_CHAR, d, 1'($urandom), 4'($urandom),
                                   ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom),
                                   8'($urandom)));
                added++;
            end else if (pick <= 7) begin
                queue_item(mk_item(OP_SEND_LINE, d, 1'($urandom), 4'($urandom),
                                   8'($urandom), 8'($urandom)));
                added++;
            end else begin
                queue_item(mk_item((pick == 8) ? OP_RX_BYTE : OP_POLL_END, d, 1'($urandom),
                                   4'($urandom), 8'($urandom), 8'($urandom)));
                added++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_op            = OP_WRITE_CHAR;
        i_display_index = 1'b0;
        i_line_select   = 1'b0;
        i_column        = 4'd0;
        i_char_value    = 8'd0;
        i_rx_byte       = 8'd0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        foreach (char_mem[k])
            char_mem[k] = CHAR_SPACE;
        for (int dd = 0; dd < DISPLAYS; dd++) begin
            reply_cnt[dd]  = '0;
            button_mem[dd] = 8'd0;
            for (int k = 0; k < RX_KEEP; k++)
                reply_mem[dd][k] = 8'd0;
        end
        enable_mask    = 2'd0;
        backlight_mask = 2'd3;

        // Out of reset both displays are disabled: polls report zero, sends are dropped.
        stim_rows.push_back(mk_poll_typed(1'b1, 8'h00, 1'b0));
        stim_rows.push_back(mk_item(OP_SEND_LINE, 1'b0, 1'b0, 4'd0, 8'd0, 8'd0));
        stim_rows.push_back(mk_reg(REG_DISPLAY_ENABLE, 2'd3));
        stim_rows.push_back(mk_item(OP_SEND_LINE, 1'b0, 1'b0, 4'd0, 8'd0, 8'd0));
        // A stored zero goes out as a space.
        stim_rows.push_back(mk_item(OP_WRITE_CHAR, 1'b0, 1'b1, 4'd0, 8'h00, 8'd0));
        stim_rows.push_back(mk_item(OP_WRITE_CHAR, 1'b0, 1'b1, 4'd15, 8'hFF, 8'd0));
        stim_rows.push_back(mk_item(OP_WRITE_CHAR, 1'b1, 1'b0, 4'd7, 8'h41, 8'd0));
        stim_rows.push_back(mk_item(OP_SEND_LINE, 1'b0, 1'b1, 4'd0, 8'd0, 8'd0));
        stim_rows.push_back(mk_reg(REG_BACKLIGHT_ON, 2'd0));
        stim_rows.push_back(mk_item(OP_SEND_LINE, 1'b1, 1'b0, 4'd0, 8'd0, 8'd0));
        // A good reply, then a second poll that finds the count cleared.
        foreach (reply_good[k])
            stim_rows.push_back(mk_item(OP_RX_BYTE, 1'b0, 1'b0, 4'd0, 8'd0, reply_good[k]));
        stim_rows.push_back(mk_poll_typed(1'b0, 8'h5A, 1'b1));
        stim_rows.push_back(mk_poll_typed(1'b0, 8'h5A, 1'b0));
        // Bad checksum is rejected and the buttons keep their old value.
        foreach (reply_bad[k])
            stim_rows.push_back(mk_item(OP_RX_BYTE, 1'b1, 1'b0, 4'd0, 8'd0, reply_bad[k]));
        stim_rows.push_back(mk_poll_typed(1'b1, 8'h00, 1'b0));
        stim_rows.push_back(mk_reg(REG_DISPLAY_ENABLE, 2'd1));
        stim_rows.push_back(mk_poll_typed(1'b1, 8'h00, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            if (stim_rows[k].is_reg) begin
                wait_idle();
                reg_write(stim_rows[k].reg_idx, stim_rows[k].reg_val);
            end else begin
                queue_item(stim_rows[k]);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            tx_steady = (p == 1 || p == 3);
            rx_steady = (p == 3);
            reg_write(REG_DISPLAY_ENABLE, phase_en[p]);
            reg_write(REG_BACKLIGHT_ON, phase_bl[p]);
            // Hold the output long enough that the engine backs up onto its input.
            if (p == 0 || p == PHASES - 1)
                hold_requests++;
            queue_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
